@@ hdl/oper_pkg.sv @@
// Shared constants and controller/datapath interface types for the odd prime extractor.
`default_nettype none

package oper_pkg;

   // Element width and default stack depth
   localparam int VALUE_W     = 32;
   localparam int STACK_DEPTH = 32;

   // Remainder unit: divisor width and bits retired per cycle
   localparam int DIVISOR_W = 16;
   localparam int RADIX_W   = 4;
   localparam int DIV_STEPS = VALUE_W / RADIX_W;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_item;     // capture the incoming element
      logic init_trial;    // divisor = 3, square = 9
      logic start_div;     // begin remainder of value by divisor
      logic div_step;      // retire one radix digit
      logic step_divisor;  // move to next odd divisor
      logic push;          // push prime or flag overflow if full
      logic load_keep;     // load output register with kept element
      logic pop_read;      // read top of stack, decrement count
      logic load_pop;      // load output register with popped prime
      logic clear_seq;     // end of sequence: clear overflow flag
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic candidate;     // odd and greater than one
      logic square_gt;     // divisor squared exceeds value
      logic div_done;      // remainder is ready
      logic rem_zero;      // divisor divides value
      logic cnt_zero;      // stack empty
      logic last;          // current element ends the sequence
      logic out_free;      // output register can take a result
   } status_type;

endpackage : oper_pkg

`default_nettype wire

@@ hdl/oper_ctrl.sv @@
// Controller state machine: sequences classification, trial division, stacking and replay.
`default_nettype none

module oper_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire oper_pkg::status_type sts,
   output oper_pkg::cmd_type        cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLASS  = 4'd1;
   localparam logic [3:0] S_CHECK  = 4'd2;
   localparam logic [3:0] S_DIV    = 4'd3;
   localparam logic [3:0] S_PUSH   = 4'd4;
   localparam logic [3:0] S_KEEP   = 4'd5;
   localparam logic [3:0] S_POPCHK = 4'd6;
   localparam logic [3:0] S_POPRD  = 4'd7;
   localparam logic [3:0] S_POPWR  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_CLASS;
            end
         end
         S_CLASS: begin
            if (sts.candidate) begin
               cmd.init_trial = 1'b1;
               state_in       = S_CHECK;
            end else begin
               state_in = S_KEEP;
            end
         end
         S_CHECK: begin
            if (sts.square_gt) begin
               state_in = S_PUSH;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (!sts.div_done) begin
               cmd.div_step = 1'b1;
            end else if (sts.rem_zero) begin
               state_in = S_KEEP;
            end else begin
               cmd.step_divisor = 1'b1;
               state_in         = S_CHECK;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = sts.last ? S_POPCHK : S_IDLE;
         end
         S_KEEP: begin
            if (sts.out_free) begin
               cmd.load_keep = 1'b1;
               state_in      = sts.last ? S_POPCHK : S_IDLE;
            end
         end
         S_POPCHK: begin
            if (sts.cnt_zero) begin
               cmd.clear_seq = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_POPRD;
            end
         end
         S_POPRD: begin
            cmd.pop_read = 1'b1;
            state_in     = S_POPWR;
         end
         S_POPWR: begin
            if (sts.out_free) begin
               cmd.load_pop = 1'b1;
               if (sts.cnt_zero) begin
                  cmd.clear_seq = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_POPRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule : oper_ctrl

`default_nettype wire

@@ hdl/oper_dp.sv @@
// Datapath: element register, trial divisor and square, radix-16 remainder unit, prime stack, output register.
`default_nettype none

module oper_dp #(
   parameter int STACK_DEPTH = oper_pkg::STACK_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic signed [oper_pkg::VALUE_W-1:0]    req_value,
   input  wire logic                                   req_end_of_list,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [oper_pkg::VALUE_W-1:0]         rsp_out_value,
   output logic                                        rsp_to_prime_list,
   output logic                                        rsp_final_result,
   output logic                                        rsp_overflow,
   input  wire oper_pkg::cmd_type                      cmd,
   output oper_pkg::status_type                        sts
);

   localparam int VW    = oper_pkg::VALUE_W;
   localparam int DW    = oper_pkg::DIVISOR_W;
   localparam int RW    = oper_pkg::RADIX_W;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DCW   = $clog2(oper_pkg::DIV_STEPS + 1);

   // Element under test
   logic [VW-1:0] value_ff;
   logic          last_ff;

   // Trial divisor and its square
   logic [DW-1:0] divisor_ff;
   logic [VW-1:0] square_ff;

   // Remainder unit
   logic [VW-1:0]  dvd_ff;
   logic [DW-1:0]  rem_ff;
   logic [DCW-1:0] div_cnt_ff;
   logic [VW-1:0]  dvd_in;
   logic [DW-1:0]  rem_in;

   // Stack
   logic [VW-1:0]    stack_mem [STACK_DEPTH];
   logic [VW-1:0]    rd_data_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_dec;
   logic             overflow_ff;
   logic             full;

   // Output register
   logic          rsp_valid_ff;
   logic [VW-1:0] out_value_ff;
   logic          to_prime_ff;
   logic          final_ff;
   logic          out_ovf_ff;

   assign cnt_dec = cnt_ff - CNT_W'(1);
   assign full    = (cnt_ff == CNT_W'(STACK_DEPTH));

   // Element capture
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         value_ff <= req_value;
         last_ff  <= req_end_of_list;
      end
   end

   // Divisor and square: (d+2)^2 = d^2 + 4d + 4
   always_ff @(posedge clock) begin
      if (cmd.init_trial) begin
         divisor_ff <= DW'(3);
         square_ff  <= VW'(9);
      end else if (cmd.step_divisor) begin
         divisor_ff <= divisor_ff + DW'(2);
         square_ff  <= square_ff + VW'({divisor_ff, 2'b00}) + VW'(4);
      end
   end

   // Four restoring remainder steps per cycle
   always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] r;
      logic [VW-1:0] sh;
      r  = rem_ff;
      sh = dvd_ff;
      for (int i = 0; i < RW; i++) begin
         t  = {r, sh[VW-1]};
         sh = {sh[VW-2:0], 1'b0};
         if (t >= {1'b0, divisor_ff}) begin
            t = t - {1'b0, divisor_ff};
         end
         r = t[DW-1:0];
      end
      rem_in = r;
      dvd_in = sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.start_div) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         dvd_ff <= value_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   // Stack storage and read port
   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         stack_mem[cnt_ff[IDX_W-1:0]] <= value_ff;
      end
      if (cmd.pop_read) begin
         rd_data_ff <= stack_mem[cnt_dec[IDX_W-1:0]];
      end
   end

   // Stack count and overflow flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         overflow_ff <= 1'b0;
      end else begin
         if (cmd.push) begin
            if (full) begin
               overflow_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end else if (cmd.pop_read) begin
            cnt_ff <= cnt_dec;
         end
         if (cmd.clear_seq) begin
            overflow_ff <= 1'b0;
         end
      end
   end

   // Output register; a transfer frees it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_keep || cmd.load_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_keep) begin
         out_value_ff <= value_ff;
         to_prime_ff  <= 1'b0;
         final_ff     <= last_ff && (cnt_ff == '0);
         out_ovf_ff   <= overflow_ff;
      end else if (cmd.load_pop) begin
         out_value_ff <= rd_data_ff;
         to_prime_ff  <= 1'b1;
         final_ff     <= (cnt_ff == '0);
         out_ovf_ff   <= overflow_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_value     = out_value_ff;
   assign rsp_to_prime_list = to_prime_ff;
   assign rsp_final_result  = final_ff;
   assign rsp_overflow      = out_ovf_ff;

   // Status back to the controller
   assign sts.candidate = value_ff[0] && !value_ff[VW-1] && (value_ff != VW'(1));
   assign sts.square_gt = (square_ff > value_ff);
   assign sts.div_done  = (div_cnt_ff == DCW'(oper_pkg::DIV_STEPS));
   assign sts.rem_zero  = (rem_ff == '0);
   assign sts.cnt_zero  = (cnt_ff == '0);
   assign sts.last      = last_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

endmodule : oper_dp

`default_nettype wire

@@ hdl/odd_prime_extract_reverse_top.sv @@
// Top level of the odd prime extractor: controller plus datapath.
//
// Usage: elements enter on the req_ channel (value, end_of_list), one transfer
// at a time; results leave on the rsp_ channel through a single output register.
// Even values, negatives, one and odd composites are passed out as kept elements
// (to_prime_list = 0). Odd values above one are tested by trial division with
// odd divisors from 3 while divisor squared <= value; primes are pushed onto
// a stack of STACK_DEPTH entries, or dropped with overflow flagged when full.
// After an element with end_of_list set, the stack is replayed newest first
// with to_prime_list = 1, the last result of the sequence carries final_result.
// Timing: req_ready is high only while the controller is idle. A non-candidate
// passes from classification straight to the output register. A candidate spends,
// per odd divisor tried, one square check, 8 remainder steps at 4 bits each and
// one test of the remainder; a large prime tries about 23170 odd divisors.
// Replay reads and then writes out each prime in turn (states POPRD, POPWR).
// A stalled receiver holds the result in the output register; the controller
// waits before loading the next one, nothing is lost.
// Reset (synchronous) empties the stack, clears overflow and the output valid.
`default_nettype none

module odd_prime_extract_reverse_top #(
   parameter int STACK_DEPTH = oper_pkg::STACK_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [oper_pkg::VALUE_W-1:0] req_value,
   input  wire logic                                req_end_of_list,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [oper_pkg::VALUE_W-1:0]      rsp_out_value,
   output logic                                     rsp_to_prime_list,
   output logic                                     rsp_final_result,
   output logic                                     rsp_overflow
);

   oper_pkg::cmd_type    cmd;
   oper_pkg::status_type sts;

   oper_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   oper_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_value         (req_value),
      .req_end_of_list   (req_end_of_list),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_value     (rsp_out_value),
      .rsp_to_prime_list (rsp_to_prime_list),
      .rsp_final_result  (rsp_final_result),
      .rsp_overflow      (rsp_overflow),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule : odd_prime_extract_reverse_top

`default_nettype wire

@@ hdl/oper_checker.sv @@
// Port-level assertions for the odd prime extractor, bound to the top level.
`default_nettype none

module oper_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [oper_pkg::VALUE_W-1:0] rsp_out_value,
   input wire logic                                rsp_to_prime_list,
   input wire logic                                rsp_final_result,
   input wire logic                                rsp_overflow
);

   // Result held until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_value) && $stable(rsp_to_prime_list)
         && $stable(rsp_final_result) && $stable(rsp_overflow))
      else $error("rsp payload changed while stalled");

   // Nothing pending after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   // One element at a time: busy right after an input transfer
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while previous element in work");

   // A kept element can close a sequence only with an empty stack, so no drop seen
   a_final_kept_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_result && !rsp_to_prime_list |-> !rsp_overflow)
      else $error("final kept result flags overflow");

endmodule : oper_checker

bind odd_prime_extract_reverse_top oper_checker u_oper_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_value     (rsp_out_value),
   .rsp_to_prime_list (rsp_to_prime_list),
   .rsp_final_result  (rsp_final_result),
   .rsp_overflow      (rsp_overflow)
);

`default_nettype wire
